// ----- rtl/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define WCN_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define WCN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/wcn_pkg.sv -----
// package of types and constants for the weekly cue nearest search
package wcn_pkg;

  localparam int TableDepth      = 16;
  localparam int TimeUnitSeconds = 60;
  localparam int DaysPerWeek     = 7;
  localparam int SecPerDay       = 86400;
  localparam int MaxUnit         = (SecPerDay - 1) / TimeUnitSeconds;
  localparam int EnableBit       = 31;
  localparam int MaskLsb         = 24;
  localparam int MaskW           = 7;
  localparam int UnitW           = 11;

  typedef logic [0:0]       mode_f_t;
  typedef logic [3:0]       idx_t;
  typedef logic [31:0]      word_t;
  typedef logic [2:0]       day_t;
  typedef logic [16:0]      time_t;
  typedef logic [19:0]      dist_t;
  typedef logic [4:0]       cnt_t;
  typedef logic [MaskW-1:0] mask_t;
  typedef logic [UnitW-1:0] unit_t;

  localparam mask_t DaysMask = mask_t'((1 << DaysPerWeek) - 1);

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/wcn_chan_if.sv -----
// request and response channel interfaces of the weekly cue nearest search
interface wcn_req_if;
  logic             valid;
  logic             ready;
  wcn_pkg::mode_f_t mode;
  wcn_pkg::idx_t    entry_index;
  wcn_pkg::word_t   entry_word;
  wcn_pkg::day_t    query_day;
  wcn_pkg::time_t   query_time;

  modport source (output valid, mode, entry_index, entry_word, query_day, query_time,
                  input ready);
  modport sink (input valid, mode, entry_index, entry_word, query_day, query_time,
                output ready);
endinterface

interface wcn_rsp_if;
  logic           valid;
  logic           ready;
  logic           before_found;
  wcn_pkg::idx_t  before_index;
  wcn_pkg::dist_t elapsed_seconds;
  logic           after_found;
  wcn_pkg::idx_t  after_index;
  wcn_pkg::dist_t remaining_seconds;
  logic           both_found;

  modport source (output valid, before_found, before_index, elapsed_seconds, after_found,
                  after_index, remaining_seconds, both_found, input ready);
  modport sink (input valid, before_found, before_index, elapsed_seconds, after_found,
                after_index, remaining_seconds, both_found, output ready);
endinterface

// ----- rtl/weekly_cue_nearest_search.sv -----
// weekly cue nearest search: schedule table, scan sequencer and shared distance unit
// a load request leaves the sequencer in ST_IDLE; ready stays high after it
// a query passes ST_SCAN (skipped when n is 0), ST_FLUSH and ST_DONE, n = min(active_points, 16)
// the scan reads one table entry per cycle through the registered table read port
// ready is low from query acceptance until the response register is loaded
// reset clears the sequencer, active_points and the response valid; the table keeps its data
module weekly_cue_nearest_search (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  wcn_pkg::cnt_t       cfg_wr_data,
  wcn_req_if.sink             req,
  wcn_rsp_if.source           rsp
);

  wcn_pkg::word_t  table_mem [wcn_pkg::TableDepth];

  wcn_pkg::state_t state, state_next;
  wcn_pkg::cnt_t   active_points;
  wcn_pkg::cnt_t   cnt, cnt_next;
  wcn_pkg::cnt_t   n_q;
  wcn_pkg::day_t   day_q;
  wcn_pkg::time_t  t_q;

  logic            rd_en;
  logic            load_rsp;
  logic            req_fire;
  logic            is_query;

  logic            s1_v;
  wcn_pkg::idx_t   s1_idx;
  wcn_pkg::word_t  rdata;

  logic            s2_v;
  wcn_pkg::idx_t   s2_idx;
  wcn_pkg::mask_t  s2_mask;
  wcn_pkg::time_t  s2_cue;

  logic            bf, af;
  wcn_pkg::idx_t   bi, ai;
  wcn_pkg::dist_t  bd, ad;

  wcn_pkg::day_t   day_red;
  wcn_pkg::time_t  t_sat;
  wcn_pkg::cnt_t   n_clamp;

  wcn_pkg::mask_t  rd_mask;
  wcn_pkg::unit_t  rd_unit;
  logic            rd_ok;

  wcn_pkg::day_t   bk, fw, stepb, stepa;
  logic            hitb, hita;
  wcn_pkg::dist_t  db, da;

  assign req.ready = (state == wcn_pkg::ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign is_query  = (wcn_pkg::mode_t'(req.mode) == wcn_pkg::MODE_QUERY);

  // query operand conditioning
  always_comb begin
    day_red = req.query_day;
    for (int i = 0; i < 7; i++) begin
      if (day_red >= wcn_pkg::day_t'(wcn_pkg::DaysPerWeek)) begin
        day_red = day_red - wcn_pkg::day_t'(wcn_pkg::DaysPerWeek);
      end
    end
    t_sat   = (req.query_time > wcn_pkg::time_t'(wcn_pkg::SecPerDay - 1))
              ? wcn_pkg::time_t'(wcn_pkg::SecPerDay - 1) : req.query_time;
    n_clamp = (active_points > wcn_pkg::cnt_t'(wcn_pkg::TableDepth))
              ? wcn_pkg::cnt_t'(wcn_pkg::TableDepth) : active_points;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcn_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    rd_en      = 1'b0;
    load_rsp   = 1'b0;
    unique case (state)
      wcn_pkg::ST_IDLE: begin
        if (req_fire && is_query) begin
          cnt_next   = '0;
          state_next = (n_clamp == '0) ? wcn_pkg::ST_FLUSH : wcn_pkg::ST_SCAN;
        end
      end
      wcn_pkg::ST_SCAN: begin
        rd_en    = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == n_q - 1'b1) begin
          state_next = wcn_pkg::ST_FLUSH;
        end
      end
      wcn_pkg::ST_FLUSH: begin
        if (!s1_v) begin
          state_next = wcn_pkg::ST_DONE;
        end
      end
      wcn_pkg::ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = wcn_pkg::ST_IDLE;
        end
      end
      default: state_next = wcn_pkg::ST_IDLE;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_points <= '0;
    end else if (cfg_wr_en) begin
      active_points <= cfg_wr_data;
    end
  end

  // schedule table
  always_ff @(posedge clk) begin
    if (req_fire && !is_query && (int'(req.entry_index) < wcn_pkg::TableDepth)) begin
      table_mem[req.entry_index] <= req.entry_word;
    end
    if (rd_en) begin
      rdata <= table_mem[cnt[3:0]];
    end
  end

  // entry decode
  assign rd_mask = rdata[wcn_pkg::MaskLsb +: wcn_pkg::MaskW] & wcn_pkg::DaysMask;
  assign rd_unit = rdata[wcn_pkg::UnitW-1:0];
  assign rd_ok   = s1_v && rdata[wcn_pkg::EnableBit] && (rd_mask != '0)
                   && (int'(rd_unit) <= wcn_pkg::MaxUnit);

  // shared distance unit
  always_comb begin
    bk    = day_q;
    fw    = day_q;
    stepb = '0;
    stepa = '0;
    hitb  = 1'b0;
    hita  = 1'b0;
    for (int i = 1; i <= wcn_pkg::DaysPerWeek; i++) begin
      bk = (bk == '0) ? wcn_pkg::day_t'(wcn_pkg::DaysPerWeek - 1) : bk - 1'b1;
      fw = (fw == wcn_pkg::day_t'(wcn_pkg::DaysPerWeek - 1)) ? '0 : fw + 1'b1;
      if (!hitb && s2_mask[bk]) begin
        hitb  = 1'b1;
        stepb = wcn_pkg::day_t'(i - 1);
      end
      if (!hita && s2_mask[fw]) begin
        hita  = 1'b1;
        stepa = wcn_pkg::day_t'(i - 1);
      end
    end
    if (s2_mask[day_q] && (s2_cue <= t_q)) begin
      db = wcn_pkg::dist_t'(t_q) - wcn_pkg::dist_t'(s2_cue);
    end else begin
      db = wcn_pkg::dist_t'(wcn_pkg::SecPerDay) - wcn_pkg::dist_t'(s2_cue)
           + wcn_pkg::dist_t'(int'(stepb) * wcn_pkg::SecPerDay) + wcn_pkg::dist_t'(t_q);
    end
    if (s2_mask[day_q] && (s2_cue > t_q)) begin
      da = wcn_pkg::dist_t'(s2_cue) - wcn_pkg::dist_t'(t_q);
    end else begin
      da = wcn_pkg::dist_t'(wcn_pkg::SecPerDay) - wcn_pkg::dist_t'(t_q)
           + wcn_pkg::dist_t'(int'(stepa) * wcn_pkg::SecPerDay) + wcn_pkg::dist_t'(s2_cue);
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= rd_en;
      s2_v <= rd_ok;
    end
  end

  // query operands, pipeline payload and running best
  always_ff @(posedge clk) begin
    if (req_fire && is_query) begin
      day_q <= day_red;
      t_q   <= t_sat;
      n_q   <= n_clamp;
      bf    <= 1'b0;
      bi    <= '0;
      bd    <= '0;
      af    <= 1'b0;
      ai    <= '0;
      ad    <= '0;
    end else if (s2_v) begin
      if ((!bf || (db < bd)) && hitb) begin
        bf <= 1'b1;
        bi <= s2_idx;
        bd <= db;
      end
      if ((!af || (da < ad)) && hita) begin
        af <= 1'b1;
        ai <= s2_idx;
        ad <= da;
      end
    end
    s1_idx  <= cnt[3:0];
    s2_idx  <= s1_idx;
    s2_mask <= rd_mask;
    s2_cue  <= wcn_pkg::time_t'(int'(rd_unit) * wcn_pkg::TimeUnitSeconds);
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.before_found      <= bf;
      rsp.before_index      <= bi;
      rsp.elapsed_seconds   <= bd;
      rsp.after_found       <= af;
      rsp.after_index       <= ai;
      rsp.remaining_seconds <= ad;
      rsp.both_found        <= bf && af;
    end
  end

endmodule

// ----- rtl/wcn_checker.sv -----
// port checker of the weekly cue nearest search and its bind
`include "assert_macros.svh"

module wcn_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           req_mode,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input logic           before_found,
  input wcn_pkg::idx_t  before_index,
  input wcn_pkg::dist_t elapsed_seconds,
  input logic           after_found,
  input wcn_pkg::idx_t  after_index,
  input wcn_pkg::dist_t remaining_seconds,
  input logic           both_found
);

  `WCN_ASSERT_RST(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(before_index) && $stable(elapsed_seconds) && $stable(after_index) && $stable(remaining_seconds), "stalled response changed")
  `WCN_ASSERT_ALWAYS(a_both, clk, rsp_valid |-> (both_found == (before_found && after_found)), "both_found mismatch")
  `WCN_ASSERT_ALWAYS(a_before_zero, clk, rsp_valid && !before_found |-> before_index == '0 && elapsed_seconds == '0, "missing before cue not zeroed")
  `WCN_ASSERT_ALWAYS(a_after_pos, clk, rsp_valid |-> (after_found ? remaining_seconds != '0 : (after_index == '0 && remaining_seconds == '0)), "bad after cue")
  `WCN_ASSERT_RST(a_query_busy, clk, rst, req_valid && req_ready && req_mode |=> !req_ready, "ready high after query request")

endmodule

bind weekly_cue_nearest_search wcn_checker u_wcn_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_mode          (req.mode),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .before_found      (rsp.before_found),
  .before_index      (rsp.before_index),
  .elapsed_seconds   (rsp.elapsed_seconds),
  .after_found       (rsp.after_found),
  .after_index       (rsp.after_index),
  .remaining_seconds (rsp.remaining_seconds),
  .both_found        (rsp.both_found)
);

// ----- dv/tb_weekly_cue_nearest_search.sv -----
// testbench for the weekly cue nearest search: random loads and queries checked by a scoreboard
module tb_weekly_cue_nearest_search;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 24;
  localparam int HoldCycles   = 300;

  typedef struct packed {
    wcn_pkg::mode_t mode;
    wcn_pkg::idx_t  entry_index;
    wcn_pkg::word_t entry_word;
    wcn_pkg::day_t  query_day;
    wcn_pkg::time_t query_time;
  } cue_req_t;

  typedef struct packed {
    logic           before_found;
    wcn_pkg::idx_t  before_index;
    wcn_pkg::dist_t elapsed_seconds;
    logic           after_found;
    wcn_pkg::idx_t  after_index;
    wcn_pkg::dist_t remaining_seconds;
    logic           both_found;
  } cue_rsp_t;

  class cue_search_board;
    wcn_pkg::word_t slots[wcn_pkg::TableDepth];
    wcn_pkg::cnt_t  points;
    cue_rsp_t       due_cues[$];
    int unsigned    errors;

    function new();
      points = '0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    function cue_rsp_t nearest_cues(wcn_pkg::day_t qday, wcn_pkg::time_t qtime);
      cue_rsp_t    res;
      int unsigned day, t, n, mask, unit, cue, d, k;
      bit          hit;
      res = '0;
      day = qday % wcn_pkg::DaysPerWeek;
      t = (qtime > wcn_pkg::SecPerDay - 1) ? wcn_pkg::SecPerDay - 1 : qtime;
      n = (points > wcn_pkg::TableDepth) ? wcn_pkg::TableDepth : points;
      for (int i = 0; i < n; i++) begin
        if (!slots[i][wcn_pkg::EnableBit]) continue;
        mask = (slots[i] >> wcn_pkg::MaskLsb) & wcn_pkg::DaysMask;
        unit = slots[i][wcn_pkg::UnitW-1:0];
        if (mask == 0 || unit > wcn_pkg::MaxUnit) continue;
        cue = unit * wcn_pkg::TimeUnitSeconds;
        // latest occurrence at or before the query, stepping back from the query day
        hit = 1'b0;
        if (((mask >> day) & 1) != 0 && cue <= t) begin
          d = t - cue;
          hit = 1'b1;
        end else begin
          for (k = 1; k <= wcn_pkg::DaysPerWeek; k++) begin
            if (((mask >> ((day + wcn_pkg::DaysPerWeek - k) % wcn_pkg::DaysPerWeek)) & 1)
                != 0) begin
              d = (wcn_pkg::SecPerDay - cue) + (k - 1) * wcn_pkg::SecPerDay + t;
              hit = 1'b1;
              break;
            end
          end
        end
        if (hit && (!res.before_found || d < res.elapsed_seconds)) begin
          res.before_found    = 1'b1;
          res.before_index    = wcn_pkg::idx_t'(i);
          res.elapsed_seconds = wcn_pkg::dist_t'(d);
        end
        // next occurrence strictly after the query
        hit = 1'b0;
        if (((mask >> day) & 1) != 0 && cue > t) begin
          d = cue - t;
          hit = 1'b1;
        end else begin
          for (k = 1; k <= wcn_pkg::DaysPerWeek; k++) begin
            if (((mask >> ((day + k) % wcn_pkg::DaysPerWeek)) & 1) != 0) begin
              d = (wcn_pkg::SecPerDay - t) + (k - 1) * wcn_pkg::SecPerDay + cue;
              hit = 1'b1;
              break;
            end
          end
        end
        if (hit && (!res.after_found || d < res.remaining_seconds)) begin
          res.after_found       = 1'b1;
          res.after_index       = wcn_pkg::idx_t'(i);
          res.remaining_seconds = wcn_pkg::dist_t'(d);
        end
      end
      res.both_found = res.before_found && res.after_found;
      return res;
    endfunction

    function void note_request(cue_req_t r);
      if (r.mode == wcn_pkg::MODE_LOAD) slots[r.entry_index] = r.entry_word;
      else due_cues.push_back(nearest_cues(r.query_day, r.query_time));
    endfunction

    task check_result(cue_rsp_t got);
      cue_rsp_t want;
      if (due_cues.size() == 0) begin
        report("response with no query waiting");
        return;
      end
      want = due_cues.pop_front();
      if (got.before_found !== want.before_found)
        report($sformatf("before_found got %0d want %0d", got.before_found, want.before_found));
      if (got.before_index !== want.before_index)
        report($sformatf("before_index got %0d want %0d", got.before_index, want.before_index));
      if (got.elapsed_seconds !== want.elapsed_seconds)
        report($sformatf("elapsed_seconds got %0d want %0d", got.elapsed_seconds,
                         want.elapsed_seconds));
      if (got.after_found !== want.after_found)
        report($sformatf("after_found got %0d want %0d", got.after_found, want.after_found));
      if (got.after_index !== want.after_index)
        report($sformatf("after_index got %0d want %0d", got.after_index, want.after_index));
      if (got.remaining_seconds !== want.remaining_seconds)
        report($sformatf("remaining_seconds got %0d want %0d", got.remaining_seconds,
                         want.remaining_seconds));
      if (got.both_found !== want.both_found)
        report($sformatf("both_found got %0d want %0d", got.both_found, want.both_found));
    endtask
  endclass

  bit            clk;
  logic          rst;
  logic          cfg_wr_en;
  wcn_pkg::cnt_t cfg_wr_data;

  wcn_req_if req_ch();
  wcn_rsp_if rsp_ch();

  cue_search_board board = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_asks;
  int unsigned holds_served;
  int unsigned cycles;

  weekly_cue_nearest_search dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sample configuration writes and both handshakes
  always @(posedge clk) begin
    cue_req_t r;
    cue_rsp_t g;
    if (!rst) begin
      if (cfg_wr_en) board.points = cfg_wr_data;
      if (req_ch.valid && req_ch.ready) begin
        r.mode        = wcn_pkg::mode_t'(req_ch.mode);
        r.entry_index = req_ch.entry_index;
        r.entry_word  = req_ch.entry_word;
        r.query_day   = req_ch.query_day;
        r.query_time  = req_ch.query_time;
        board.note_request(r);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        g.before_found      = rsp_ch.before_found;
        g.before_index      = rsp_ch.before_index;
        g.elapsed_seconds   = rsp_ch.elapsed_seconds;
        g.after_found       = rsp_ch.after_found;
        g.after_index       = rsp_ch.after_index;
        g.remaining_seconds = rsp_ch.remaining_seconds;
        g.both_found        = rsp_ch.both_found;
        board.check_result(g);
      end
    end
  end

  // response side: random back-pressure, with long hold-offs on demand
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_served) begin
        rsp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        holds_served++;
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic wcn_pkg::word_t schedule_word();
    wcn_pkg::word_t w;
    int unsigned    r;
    r = $urandom_range(99);
    w = $urandom;
    if (r < 60) begin
      w[wcn_pkg::EnableBit] = 1'b1;
      w[wcn_pkg::MaskLsb +: wcn_pkg::MaskW] =
        ($urandom_range(3) == 0) ? wcn_pkg::mask_t'(1 << $urandom_range(6))
                                 : wcn_pkg::mask_t'($urandom_range(1, 127));
      w[wcn_pkg::UnitW-1:0] = wcn_pkg::unit_t'($urandom_range(0, wcn_pkg::MaxUnit));
    end else if (r < 80) begin
      // copy of another slot, unused bits changed, to force ties
      w = board.slots[$urandom_range(wcn_pkg::TableDepth - 1)];
      w[23:11] = 13'($urandom);
    end else if (r < 88) begin
      w[wcn_pkg::UnitW-1:0] = wcn_pkg::unit_t'($urandom_range(0, wcn_pkg::MaxUnit));
    end
    return w;
  endfunction

  function automatic cue_req_t load_req(wcn_pkg::idx_t idx, wcn_pkg::word_t w);
    cue_req_t r;
    r = '0;
    r.mode        = wcn_pkg::MODE_LOAD;
    r.entry_index = idx;
    r.entry_word  = w;
    return r;
  endfunction

  function automatic cue_req_t query_req(wcn_pkg::day_t day, wcn_pkg::time_t t);
    cue_req_t r;
    r = '0;
    r.mode       = wcn_pkg::MODE_QUERY;
    r.query_day  = day;
    r.query_time = t;
    return r;
  endfunction

  function automatic cue_req_t random_request();
    cue_req_t    r;
    int unsigned pick, tt;
    if ($urandom_range(99) < 30)
      return load_req(wcn_pkg::idx_t'($urandom_range(15)), schedule_word());
    pick = $urandom_range(99);
    if (pick < 15) begin
      tt = $urandom_range(wcn_pkg::SecPerDay, 131071);
    end else if (pick < 40) begin
      // land on or next to a cue time held in the table
      tt = board.slots[$urandom_range(wcn_pkg::TableDepth - 1)][wcn_pkg::UnitW-1:0]
           * wcn_pkg::TimeUnitSeconds;
      case ($urandom_range(2))
        0: if (tt > 0) tt = tt - 1;
        1: tt = tt + 1;
        default: ;
      endcase
    end else if (pick < 45) begin
      tt = $urandom_range(1) ? wcn_pkg::SecPerDay - 1 : 0;
    end else begin
      tt = $urandom_range(0, wcn_pkg::SecPerDay - 1);
    end
    r = query_req(wcn_pkg::day_t'($urandom_range(7)), wcn_pkg::time_t'(tt));
    return r;
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic offer_request(cue_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.mode        <= r.mode;
    req_ch.entry_index <= r.entry_index;
    req_ch.entry_word  <= r.entry_word;
    req_ch.query_day   <= r.query_day;
    req_ch.query_time  <= r.query_time;
    req_ch.valid       <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_cues();
    req_ch.valid <= 1'b0;
    while (board.due_cues.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_points(wcn_pkg::cnt_t n);
    drain_cues();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    cue_req_t r;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_ch.valid       = 1'b0;
    req_ch.mode        = wcn_pkg::MODE_LOAD;
    req_ch.entry_index = '0;
    req_ch.entry_word  = '0;
    req_ch.query_day   = '0;
    req_ch.query_time  = '0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    hold_asks          = 0;
    holds_served       = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 53;

    // every slot written before any scan
    offer_request(load_req(4'd0, 32'hFF00_0000));
    offer_request(load_req(4'd1, 32'h8100_059F));
    offer_request(load_req(4'd2, 32'h8800_05A0));
    offer_request(load_req(4'd3, 32'h7F00_0258));
    offer_request(load_req(4'd4, 32'h8000_0064));
    offer_request(load_req(4'd5, 32'hFFFF_F800));
    offer_request(load_req(4'd6, 32'hC000_02D0));
    offer_request(load_req(4'd7, 32'hFFFF_FFFF));
    offer_request(load_req(4'd8, 32'h8800_02D0));
    for (int i = 9; i < wcn_pkg::TableDepth; i++)
      offer_request(load_req(wcn_pkg::idx_t'(i), schedule_word()));

    set_points(wcn_pkg::cnt_t'(wcn_pkg::TableDepth));
    offer_request(query_req(3'd0, 17'd0));
    offer_request(query_req(3'd6, 17'd86399));
    offer_request(query_req(3'd7, 17'd0));
    offer_request(query_req(3'd3, 17'h1FFFF));
    offer_request(query_req(3'd3, 17'd43200));
    offer_request(query_req(3'd0, 17'd86340));
    offer_request(query_req(3'd2, 17'd100));
    set_points(wcn_pkg::cnt_t'(0));
    offer_request(query_req(3'd4, 17'd5000));
    set_points(wcn_pkg::cnt_t'(31));
    offer_request(query_req(3'd1, 17'd70000));
    set_points(wcn_pkg::cnt_t'(1));
    offer_request(query_req(3'd6, 17'd86399));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 20 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        set_points(($urandom_range(3) == 0) ? wcn_pkg::cnt_t'(wcn_pkg::TableDepth)
                                            : wcn_pkg::cnt_t'($urandom_range(31)));
        repeat (75) offer_request(random_request());
        if (phase == 0 && blk == 0) begin
          // long response stall while queries keep coming
          hold_asks++;
          repeat (12) begin
            r = random_request();
            r.mode = wcn_pkg::MODE_QUERY;
            offer_request(r);
          end
        end
      end
    end

    drain_cues();
    if (board.due_cues.size() != 0) board.report("queries left without a response");
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wcn_pkg.sv
rtl/wcn_chan_if.sv
rtl/weekly_cue_nearest_search.sv
rtl/wcn_checker.sv
dv/tb_weekly_cue_nearest_search.sv
